FILE: rtl/rct_pkg.sv
// Shared types and character codes for the RESP command tokenizer.
package rct_pkg;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int RCT_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_star;
        logic       is_dollar;
        logic       is_plus;
        logic       is_minus;
        logic       is_cr;
        logic       is_lf;
    } rct_class_t;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       has_byte;
        logic       token_end;
        logic       message_end;
        logic       format_error;
    } rct_result_t;

endpackage

FILE: rtl/resp_command_tokenizer_unit.sv
// Top level of the RESP command tokenizer: front classifier, queues and parser.
// Takes one message byte per cycle while full is low and turns it into token
// words. A message starting with '*' is parsed as a RESP array of bulk strings;
// any other message is split at whitespace. Each accepted byte gives at most one
// result word, which reaches the result side through the input and output queues.
// The parser state machine in the back end handles one byte per cycle, so the
// sustained rate is one byte per cycle while pop keeps up; a two-word queue on
// each side of the parser lets input and output stall independently.
module resp_command_tokenizer_unit #(
    parameter int LENGTH_BITS = 32,
    parameter int COUNT_BITS  = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] byte_in,
    input  logic       last_byte,
    input  logic       push,
    output logic       full,
    output logic [7:0] token_byte,
    output logic       has_byte,
    output logic       token_end,
    output logic       message_end,
    output logic       format_error,
    output logic       empty,
    input  logic       pop
);
    import rct_pkg::*;

    localparam int CLS_W = $bits(rct_class_t);
    localparam int RES_W = $bits(rct_result_t);

    rct_class_t  cls_in, cls_head;
    rct_result_t res_back, res_out;
    logic        mid_empty, mid_pop;
    logic        out_full, out_push;

    rct_front u_front (
        .byte_in   (byte_in),
        .last_byte (last_byte),
        .cls       (cls_in)
    );

    rct_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (RCT_QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cls_in),
        .full  (full),
        .pop   (mid_pop),
        .dout  (cls_head),
        .empty (mid_empty)
    );

    rct_back #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls       (cls_head),
        .cls_valid (!mid_empty),
        .cls_pop   (mid_pop),
        .res_ready (!out_full),
        .res       (res_back),
        .res_push  (out_push)
    );

    rct_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RCT_QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (res_back),
        .full  (out_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign token_byte   = res_out.token_byte;
    assign has_byte     = res_out.has_byte;
    assign token_end    = res_out.token_end;
    assign message_end  = res_out.message_end;
    assign format_error = res_out.format_error;

endmodule

FILE: rtl/rct_fifo.sv
// Small synchronous queue used between the front, the back and the result port.
module rct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: rtl/rct_front.sv
// Front end: classifies each incoming byte for the parser.
module rct_front (
    input  logic              [7:0] byte_in,
    input  logic                    last_byte,
    output rct_pkg::rct_class_t     cls
);
    import rct_pkg::*;

    always_comb
    begin
        cls.byte_val  = byte_in;
        cls.last      = last_byte;
        cls.is_space  = (byte_in == CH_SPACE) || (byte_in >= CH_TAB && byte_in <= CH_CR);
        cls.is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
        cls.digit     = byte_in[3:0];
        cls.is_star   = (byte_in == CH_STAR);
        cls.is_dollar = (byte_in == CH_DOLLAR);
        cls.is_plus   = (byte_in == CH_PLUS);
        cls.is_minus  = (byte_in == CH_MINUS);
        cls.is_cr     = (byte_in == CH_CR);
        cls.is_lf     = (byte_in == CH_LF);
    end

endmodule

FILE: rtl/rct_back.sv
// Back end: message parser state machine, one classified byte per cycle while res_ready.
module rct_back #(
    parameter int LENGTH_BITS = 32,
    parameter int COUNT_BITS  = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rct_pkg::rct_class_t      cls,
    input  logic                     cls_valid,
    output logic                     cls_pop,
    input  logic                     res_ready,
    output rct_pkg::rct_result_t     res,
    output logic                     res_push
);
    import rct_pkg::*;

    localparam int ACC_W = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;
    localparam int MUL_W = ACC_W + 4;

    typedef enum logic [3:0] {
        ST_START, ST_WS, ST_CNT0, ST_CNTS, ST_CNTD, ST_CNTLF, ST_DOLLAR, ST_LEN0,
        ST_LENS, ST_LEND, ST_LENLF, ST_PAY, ST_SKIP, ST_DRAIN, ST_ERR
    } state_t;

    state_t                 state_reg, state_next, eff_state;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic [COUNT_BITS-1:0]  elems_reg, elems_next;
    logic [LENGTH_BITS-1:0] bytes_reg, bytes_next;
    logic [1:0]             skip_reg, skip_next;
    logic                   word_reg, word_next, word_cur;
    logic [MUL_W-1:0]       acc_sum;
    logic                   cnt_ovf, len_ovf;
    logic                   hb, te, me, err, complete, fire;

    assign fire     = cls_valid && res_ready;
    assign cls_pop  = fire;
    assign acc_sum  = (MUL_W'(acc_reg) << 3) + (MUL_W'(acc_reg) << 1) + MUL_W'(cls.digit);
    assign cnt_ovf  = (acc_sum >> COUNT_BITS) != '0;
    assign len_ovf  = (acc_sum >> LENGTH_BITS) != '0;
    assign word_cur = (state_reg == ST_START) ? 1'b0 : word_reg;
    assign eff_state = (state_reg == ST_START && !cls.is_star) ? ST_WS : state_reg;

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        elems_next = elems_reg;
        bytes_next = bytes_reg;
        skip_next  = skip_reg;
        word_next  = word_cur;
        hb         = 1'b0;
        te         = 1'b0;
        me         = 1'b0;
        err        = 1'b0;
        complete   = 1'b0;

        unique case (eff_state) inside
            ST_START:
            begin
                state_next = ST_CNT0;
                acc_next   = '0;
                neg_next   = 1'b0;
            end
            ST_WS:
            begin
                state_next = ST_WS;
                if (cls.is_space)
                begin
                    te        = word_cur;
                    word_next = 1'b0;
                end
                else
                begin
                    hb        = 1'b1;
                    word_next = 1'b1;
                end
            end
            ST_CNT0:
            begin
                if (cls.is_minus)
                begin
                    neg_next   = 1'b1;
                    state_next = ST_CNTS;
                end
                else if (cls.is_plus)
                begin
                    state_next = ST_CNTS;
                end
                else if (cls.is_digit)
                begin
                    acc_next   = ACC_W'(cls.digit);
                    state_next = ST_CNTD;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            ST_CNTS:
            begin
                if (cls.is_digit)
                begin
                    acc_next   = ACC_W'(cls.digit);
                    state_next = ST_CNTD;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            ST_CNTD:
            begin
                if (cls.is_digit)
                begin
                    if (cnt_ovf)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_sum[ACC_W-1:0];
                    end
                end
                else if (cls.is_cr)
                begin
                    state_next = ST_CNTLF;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            ST_CNTLF:
            begin
                if (!cls.is_lf)
                begin
                    err = 1'b1;
                end
                else if (neg_reg || acc_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    elems_next = acc_reg[COUNT_BITS-1:0];
                    state_next = ST_DOLLAR;
                end
            end
            ST_DOLLAR:
            begin
                if (cls.is_dollar)
                begin
                    acc_next   = '0;
                    state_next = ST_LEN0;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            ST_LEN0, ST_LENS:
            begin
                if (eff_state == ST_LEN0 && cls.is_plus)
                begin
                    state_next = ST_LENS;
                end
                else if (cls.is_digit)
                begin
                    acc_next   = ACC_W'(cls.digit);
                    state_next = ST_LEND;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            ST_LEND:
            begin
                if (cls.is_digit)
                begin
                    if (len_ovf)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_sum[ACC_W-1:0];
                    end
                end
                else if (cls.is_cr)
                begin
                    state_next = ST_LENLF;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            ST_LENLF:
            begin
                if (!cls.is_lf)
                begin
                    err = 1'b1;
                end
                else if (acc_reg == '0)
                begin
                    te         = 1'b1;
                    elems_next = elems_reg - 1'b1;
                    skip_next  = 2'd2;
                    state_next = ST_SKIP;
                end
                else
                begin
                    bytes_next = acc_reg[LENGTH_BITS-1:0];
                    state_next = ST_PAY;
                end
            end
            ST_PAY:
            begin
                hb         = 1'b1;
                bytes_next = bytes_reg - 1'b1;
                if (bytes_reg == LENGTH_BITS'(1))
                begin
                    te         = 1'b1;
                    elems_next = elems_reg - 1'b1;
                    skip_next  = 2'd2;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                skip_next = skip_reg - 1'b1;
                if (skip_reg == 2'd1)
                begin
                    state_next = (elems_reg != '0) ? ST_DOLLAR : ST_DRAIN;
                end
            end
            ST_DRAIN, ST_ERR:
            begin
            end
            default:
            begin
            end
        endcase

        if (err)
        begin
            state_next = ST_ERR;
        end

        if (cls.last)
        begin
            me = 1'b1;
            if (!err)
            begin
                complete = (state_next == ST_WS) || (state_next == ST_DRAIN) ||
                           (state_next == ST_ERR) ||
                           (state_next == ST_SKIP && elems_next == '0);
                if (state_next == ST_WS && word_next)
                begin
                    te = 1'b1;
                end
                if (!complete)
                begin
                    err = 1'b1;
                end
            end
            state_next = ST_START;
            acc_next   = '0;
            neg_next   = 1'b0;
            elems_next = '0;
            bytes_next = '0;
            skip_next  = '0;
            word_next  = 1'b0;
        end

        res.token_byte   = hb ? cls.byte_val : 8'h00;
        res.has_byte     = hb;
        res.token_end    = te;
        res.message_end  = me;
        res.format_error = err;
        res_push         = fire && (hb || te || me || err);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            elems_reg <= '0;
            bytes_reg <= '0;
            skip_reg  <= '0;
            word_reg  <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            elems_reg <= elems_next;
            bytes_reg <= bytes_next;
            skip_reg  <= skip_next;
            word_reg  <= word_next;
        end
    end

endmodule
